[rtl/core/vnf_pkg.sv]
// ----------------------------------------------------------------------------
// vnf_pkg
// Shared constants and types for the 3-D value noise core.
// ----------------------------------------------------------------------------
package vnf_pkg;

   localparam int DEF_MAX_OCTAVES = 8;
   localparam int OCT_W           = 5;
   localparam int COORD_W         = 32;
   localparam int CORNER_W        = 24;
   localparam int RES_W           = 16;

   localparam logic [31:0] HASH_K1 = 32'h7feb352d;
   localparam logic [31:0] HASH_K2 = 32'h846ca68b;
   localparam logic [2:0][31:0] PRIME = {32'hcb1ab31f, 32'hd8163841, 32'h8da6b343};
   localparam logic [17:0] OCT_SCALE = 18'd133038;

   localparam logic [3:0] OCT_RESET    = 4'd4;
   localparam logic       REG_OCTAVES  = 1'b0;
   localparam logic       REG_MODE     = 1'b1;
   localparam logic       MODE_FRACTAL = 1'b0;
   localparam logic       MODE_RIDGED  = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [OCT_W-1:0]          octaves;
      logic                      mode;
   } job_type;

endpackage

[rtl/core/vnf_hash.sv]
// ----------------------------------------------------------------------------
// vnf_hash
// Three-stage multiply-xorshift corner hash, one corner per cycle.
// ----------------------------------------------------------------------------
module vnf_hash
   import vnf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [31:0]         in_seed,
   output logic                out_valid,
   output logic [CORNER_W-1:0] out_value
);

   logic [31:0] s0_ff, s1_ff, s2_ff;
   logic [2:0]  v_ff;
   logic [31:0] x0_in, x1_in, x2_in;

   assign x0_in = s0_ff ^ (s0_ff >> 16);
   assign x1_in = s1_ff ^ (s1_ff >> 15);
   assign x2_in = s2_ff ^ (s2_ff >> 16);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[1:0], in_valid};
      end
      s0_ff <= in_seed;
      s1_ff <= x0_in * HASH_K1;
      s2_ff <= x1_in * HASH_K2;
   end

   assign out_valid = v_ff[2];
   assign out_value = x2_in[31:8];

endmodule

[rtl/core/vnf_front.sv]
// ----------------------------------------------------------------------------
// vnf_front
// Takes requests, resolves the octave count and queues them for the engine.
// ----------------------------------------------------------------------------
module vnf_front
   import vnf_pkg::*;
#(
   parameter int MAX_OCTAVES = DEF_MAX_OCTAVES
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] coord_x,
   input  logic signed [COORD_W-1:0] coord_y,
   input  logic signed [COORD_W-1:0] coord_z,
   input  logic [3:0]                octave_count,
   input  logic                      noise_mode,
   output logic                      job_valid,
   output job_type                   job,
   input  logic                      job_pop
);

   job_type    slot_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff;
   logic       push;
   job_type    job_in;
   logic [OCT_W-1:0] oct_in;

   always_comb begin
      oct_in = OCT_W'(octave_count);
      if (octave_count == 4'd0) begin
         oct_in = OCT_W'(1);
      end else if (OCT_W'(octave_count) > OCT_W'(MAX_OCTAVES)) begin
         oct_in = OCT_W'(MAX_OCTAVES);
      end
      job_in = '{x: coord_x, y: coord_y, z: coord_z, octaves: oct_in, mode: noise_mode};
   end

   assign busy      = (count_ff == 2'd2);
   assign push      = start && !busy;
   assign job_valid = (count_ff != 2'd0);
   assign job       = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (job_pop) begin
            rd_ff <= !rd_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(job_pop);
      end
      if (push) begin
         slot_ff[wr_ff] <= job_in;
      end
   end

endmodule

[rtl/core/vnf_back.sv]
// ----------------------------------------------------------------------------
// vnf_back
// Octave engine: lattice setup, corner hashing, trilinear blend, octave
// accumulation, normalising divide and ridged fold.
// ----------------------------------------------------------------------------
module vnf_back
   import vnf_pkg::*;
#(
   parameter int MAX_OCTAVES = DEF_MAX_OCTAVES
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  job_type          job,
   output logic             job_pop,
   output logic             rsp_valid,
   output logic [RES_W-1:0] rsp_noise_value
);

   localparam int ACC_W = CORNER_W + MAX_OCTAVES;
   localparam int REM_W = ACC_W - 8;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SETUP, ST_FADE, ST_HASH, ST_BLEND, ST_ACC, ST_DIV, ST_RIDGE
   } state_type;

   function automatic logic [CORNER_W-1:0] blend(input logic [CORNER_W-1:0] a,
                                                 input logic [CORNER_W-1:0] b,
                                                 input logic [15:0] w);
      logic [40:0] s;
      s = ({17'b0, a} * {24'b0, 17'h10000 - {1'b0, w}}) + ({17'b0, b} * {25'b0, w});
      return s[39:16];
   endfunction

   function automatic logic signed [31:0] sat_scale(input logic signed [49:0] p);
      logic signed [49:0] r;
      r = (p + 50'sd32768) >>> 16;
      if (r > 50'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (r < -50'sd2147483648) begin
         return 32'sh80000000;
      end
      return r[31:0];
   endfunction

   state_type            state_ff;
   logic signed [31:0]   crd_ff [3];
   logic [15:0]          t_ff [3];
   logic [31:0]          tt_ff [3];
   logic signed [49:0]   ps_ff [3];
   logic [31:0]          a0_ff [3];
   logic [31:0]          a1_ff [3];
   logic [15:0]          w_ff [3];
   logic [CORNER_W-1:0]  v_ff [8];
   logic [3:0]           len_ff, iss_ff;
   logic [OCT_W-1:0]     k_ff, oct_ff;
   logic                 mode_ff;
   logic [ACC_W-1:0]     acc_ff;
   logic [REM_W-1:0]     rem_ff;
   logic [15:0]          quo_ff;
   logic [3:0]           bit_ff;
   logic [49:0]          rr_ff;
   logic                 rsp_valid_ff;
   logic [RES_W-1:0]     rsp_value_ff;

   logic                 h_issue, h_valid;
   logic [31:0]          h_seed;
   logic [CORNER_W-1:0]  h_value;
   logic [15:0]          w_sel;
   logic [CORNER_W-1:0]  blend_in;
   logic [3:0]           len_m2;
   logic [ACC_W-1:0]     acc_in;
   logic [OCT_W-1:0]     shamt;
   logic [REM_W-1:0]     divisor, trial;
   logic                 ge;
   logic [15:0]          quo_in;
   logic [24:0]          n2, fold, ridge;
   logic [17:0]          rr_hi;

   assign h_issue = (state_ff == ST_HASH) && (iss_ff < 4'd8);
   assign h_seed  = (iss_ff[0] ? a1_ff[0] : a0_ff[0]) +
                    (iss_ff[1] ? a1_ff[1] : a0_ff[1]) +
                    (iss_ff[2] ? a1_ff[2] : a0_ff[2]);

   vnf_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (h_issue),
      .in_seed   (h_seed),
      .out_valid (h_valid),
      .out_value (h_value)
   );

   always_comb begin
      if (len_ff > 4'd4) begin
         w_sel = w_ff[0];
      end else if (len_ff > 4'd2) begin
         w_sel = w_ff[1];
      end else begin
         w_sel = w_ff[2];
      end
   end

   assign blend_in = blend(v_ff[0], v_ff[1], w_sel);
   assign len_m2   = len_ff - 4'd2;
   assign shamt    = k_ff - OCT_W'(1) - oct_ff;
   assign acc_in   = acc_ff + (ACC_W'(v_ff[0]) << shamt);
   assign divisor  = (REM_W'(1) << k_ff) - REM_W'(1);
   assign trial    = divisor << bit_ff;
   assign ge       = (rem_ff >= trial);
   assign quo_in   = quo_ff | (16'(ge) << bit_ff);
   assign n2       = {v_ff[0], 1'b0};
   assign fold     = (n2 >= 25'h1000000) ? n2 - 25'h1000000 : 25'h1000000 - n2;
   assign ridge    = 25'h1000000 - fold;
   assign rr_hi    = rr_ff[49:32];
   assign job_pop  = (state_ff == ST_IDLE) && job_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  crd_ff[0] <= job.x;
                  crd_ff[1] <= job.y;
                  crd_ff[2] <= job.z;
                  k_ff      <= job.octaves;
                  mode_ff   <= job.mode;
                  oct_ff    <= '0;
                  acc_ff    <= '0;
                  state_ff  <= ST_SETUP;
               end
            end
            ST_SETUP: begin
               for (int a = 0; a < 3; a++) begin
                  t_ff[a]  <= crd_ff[a][15:0];
                  tt_ff[a] <= {16'b0, crd_ff[a][15:0]} * {16'b0, crd_ff[a][15:0]};
                  a0_ff[a] <= {{16{crd_ff[a][31]}}, crd_ff[a][31:16]} * PRIME[a];
                  ps_ff[a] <= $signed({{18{crd_ff[a][31]}}, crd_ff[a]}) *
                              $signed({32'b0, OCT_SCALE});
               end
               state_ff <= ST_FADE;
            end
            ST_FADE: begin
               for (int a = 0; a < 3; a++) begin
                  logic [49:0] fp;
                  fp = {18'b0, tt_ff[a]} *
                       {32'b0, 18'd196608 - {1'b0, t_ff[a], 1'b0}};
                  w_ff[a]   <= fp[47:32];
                  a1_ff[a]  <= a0_ff[a] + PRIME[a];
                  crd_ff[a] <= sat_scale(ps_ff[a]);
               end
               iss_ff   <= '0;
               len_ff   <= '0;
               state_ff <= ST_HASH;
            end
            ST_HASH: begin
               if (h_issue) begin
                  iss_ff <= iss_ff + 4'd1;
               end
               if (h_valid) begin
                  v_ff[len_ff[2:0]] <= h_value;
                  len_ff <= len_ff + 4'd1;
               end
               if (len_ff == 4'd8) begin
                  state_ff <= ST_BLEND;
               end
            end
            ST_BLEND: begin
               for (int i = 0; i < 6; i++) begin
                  v_ff[i] <= v_ff[i+2];
               end
               v_ff[len_m2[2:0]] <= blend_in;
               len_ff <= len_ff - 4'd1;
               if (len_ff == 4'd2) begin
                  state_ff <= ST_ACC;
               end
            end
            ST_ACC: begin
               if (mode_ff == MODE_RIDGED) begin
                  rr_ff    <= {25'b0, ridge} * {25'b0, ridge};
                  state_ff <= ST_RIDGE;
               end else begin
                  acc_ff <= acc_in;
                  oct_ff <= oct_ff + OCT_W'(1);
                  if (oct_ff + OCT_W'(1) == k_ff) begin
                     rem_ff   <= REM_W'(acc_in >> 8);
                     quo_ff   <= '0;
                     bit_ff   <= 4'd15;
                     state_ff <= ST_DIV;
                  end else begin
                     state_ff <= ST_SETUP;
                  end
               end
            end
            ST_DIV: begin
               if (ge) begin
                  rem_ff <= rem_ff - trial;
               end
               quo_ff <= quo_in;
               bit_ff <= bit_ff - 4'd1;
               if (bit_ff == 4'd0) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= quo_in;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_RIDGE: begin
               rsp_valid_ff <= 1'b1;
               rsp_value_ff <= (rr_hi > 18'd65535) ? 16'hffff : rr_hi[15:0];
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_value_ff;

   a_single_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff) else $error("result strobe held");
   a_tree_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC) |-> (len_ff == 4'd1)) else $error("blend tree not reduced");
   a_hash_owned: assert property (@(posedge clock) disable iff (reset)
      h_valid |-> (state_ff == ST_HASH)) else $error("stray corner hash");
   a_div_fractal: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (mode_ff == MODE_FRACTAL)) else $error("divide in ridged mode");

endmodule

[rtl/core/value_noise_fbm_3d_core.sv]
// ----------------------------------------------------------------------------
// value_noise_fbm_3d_core
// Fractal / ridged 3-D value noise on Q16.16 points, result in Q0.16.
// ----------------------------------------------------------------------------
// channel   ports                                   handshake
// request   req_coord_x/y/z                         start, busy
// result    rsp_noise_value                         rsp_valid strobe
// csr       psel penable pwrite paddr pwdata prdata pready (always ready)
//
// Each octave: setup, fade, 8 corners through the 3-stage hash, 7 blends,
// accumulate. A fractal request holds the engine for hand-off, k octaves and
// a 16-bit divide; a ridged one for hand-off, one octave and the ridged fold.
// Two requests queue ahead of the engine; busy rises only when both slots are
// full. The result receiver cannot stall. Reset is synchronous, clears control.
// ----------------------------------------------------------------------------
module value_noise_fbm_3d_core
   import vnf_pkg::*;
#(
   parameter int MAX_OCTAVES = DEF_MAX_OCTAVES
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic signed [COORD_W-1:0] req_coord_z,
   output logic                      rsp_valid,
   output logic [RES_W-1:0]          rsp_noise_value,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [2:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   logic [3:0] octave_count_ff;
   logic       noise_mode_ff;
   logic       csr_wr;
   logic       job_valid, job_pop;
   job_type    job;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == REG_MODE) ? {31'b0, noise_mode_ff} : {28'b0, octave_count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         octave_count_ff <= OCT_RESET;
         noise_mode_ff   <= MODE_FRACTAL;
      end else if (csr_wr) begin
         if (paddr[2] == REG_OCTAVES) begin
            octave_count_ff <= pwdata[3:0];
         end else begin
            noise_mode_ff <= pwdata[0];
         end
      end
   end

   vnf_front #(.MAX_OCTAVES(MAX_OCTAVES)) u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .coord_x      (req_coord_x),
      .coord_y      (req_coord_y),
      .coord_z      (req_coord_z),
      .octave_count (octave_count_ff),
      .noise_mode   (noise_mode_ff),
      .job_valid    (job_valid),
      .job          (job),
      .job_pop      (job_pop)
   );

   vnf_back #(.MAX_OCTAVES(MAX_OCTAVES)) u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (job_valid),
      .job             (job),
      .job_pop         (job_pop),
      .rsp_valid       (rsp_valid),
      .rsp_noise_value (rsp_noise_value)
   );

endmodule
